[rtl/core/cmvp_pkg.sv]
// Package for the complex matrix-vector product block.
// Holds default sizes, command and register codes, and the stage control type.
// Depends on nothing; used by cmvp_mac and the top level.
package cmvp_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned MAX_DIM_DEF    = 64;
  localparam int unsigned DATA_WIDTH_DEF = 18;

  // Item commands.
  localparam logic CMD_VEC_WRITE = 1'b0;
  localparam logic CMD_MATRIX    = 1'b1;

  // Register word indexes on the configuration port.
  localparam logic REG_SIZE_IN_USE = 1'b0;

  // Control that travels with a matrix entry down the pipeline.
  typedef struct packed {
    logic valid;     // entry is in range and takes part in the sum
    logic first;     // column 0: restart the sum
    logic last;      // last column in use: emit the row sum
    logic last_row;  // row is the final row in use
  } ctrl_t;

endpackage

[rtl/core/cmvp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameters set word width and depth; depends on nothing.
module cmvp_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/cmvp_mac.sv]
// Complex multiply-accumulate datapath: products, running sum, scaling and saturation.
// Depends on cmvp_pkg for the stage control type.
module cmvp_mac #(
  parameter int unsigned DATA_WIDTH = cmvp_pkg::DATA_WIDTH_DEF,
  parameter int unsigned ROW_W      = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmvp_pkg::ctrl_t              ctrl_i,
  input  logic [ROW_W-1:0]             row_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] v_re_i,
  input  logic signed [DATA_WIDTH-1:0] v_im_i,
  output logic                         done_o,
  output logic [ROW_W-1:0]             out_row_o,
  output logic signed [DATA_WIDTH-1:0] out_real_o,
  output logic signed [DATA_WIDTH-1:0] out_imag_o,
  output logic                         last_row_o
);

  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + 1 + ROW_W;
  localparam int unsigned FRAC   = DATA_WIDTH - 2;
  // Bits of the sum that must all match the sign for the scaled value to fit.
  localparam int unsigned TOP_LO = DATA_WIDTH - 1 + FRAC;

  // Product stage.
  cmvp_pkg::ctrl_t         s2_q;
  logic [ROW_W-1:0]        s2_row_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  // Accumulate stage.
  cmvp_pkg::ctrl_t         s3_q;
  logic [ROW_W-1:0]        s3_row_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q, acc_re_d, acc_im_d;

  // Result registers.
  logic                          done_q;
  logic [ROW_W-1:0]              out_row_q;
  logic signed [DATA_WIDTH-1:0]  out_re_q, out_im_q, out_re_d, out_im_d;
  logic                          last_row_q;

  // Four partial products of the complex multiply, registered.
  always_ff @(posedge clk_i) begin
    p_rr_q   <= PROD_W'(a_re_i * v_re_i);
    p_ii_q   <= PROD_W'(a_im_i * v_im_i);
    p_ri_q   <= PROD_W'(a_re_i * v_im_i);
    p_ir_q   <= PROD_W'(a_im_i * v_re_i);
    s2_row_q <= row_i;
    s3_row_q <= s2_row_q;
  end

  // Next running sum: column 0 restarts it, other columns add to it.
  always_comb begin
    logic signed [ACC_W-1:0] base_re;
    logic signed [ACC_W-1:0] base_im;
    base_re  = s2_q.first ? '0 : acc_re_q;
    base_im  = s2_q.first ? '0 : acc_im_q;
    acc_re_d = base_re + ACC_W'(p_rr_q) - ACC_W'(p_ii_q);
    acc_im_d = base_im + ACC_W'(p_ri_q) + ACC_W'(p_ir_q);
  end

  // Shift down by the fraction width and saturate to the data range.
  always_comb begin
    logic [ACC_W-TOP_LO-1:0] top_re;
    logic [ACC_W-TOP_LO-1:0] top_im;
    top_re = acc_re_q[ACC_W-1:TOP_LO];
    top_im = acc_im_q[ACC_W-1:TOP_LO];
    if ((&top_re) || !(|top_re)) begin
      out_re_d = acc_re_q[TOP_LO:FRAC];
    end else begin
      out_re_d = {acc_re_q[ACC_W-1], {(DATA_WIDTH-1){~acc_re_q[ACC_W-1]}}};
    end
    if ((&top_im) || !(|top_im)) begin
      out_im_d = acc_im_q[TOP_LO:FRAC];
    end else begin
      out_im_d = {acc_im_q[ACC_W-1], {(DATA_WIDTH-1){~acc_im_q[ACC_W-1]}}};
    end
  end

  // Stage control, running sum and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q     <= '0;
      s3_q     <= '0;
      acc_re_q <= '0;
      acc_im_q <= '0;
      done_q   <= 1'b0;
    end else begin
      s2_q   <= ctrl_i;
      s3_q   <= s2_q;
      done_q <= s3_q.valid && s3_q.last;
      if (s2_q.valid) begin
        acc_re_q <= acc_re_d;
        acc_im_q <= acc_im_d;
      end
    end
  end

  // Result payload, loaded when a row sum completes.
  always_ff @(posedge clk_i) begin
    if (s3_q.valid && s3_q.last) begin
      out_row_q  <= s3_row_q;
      out_re_q   <= out_re_d;
      out_im_q   <= out_im_d;
      last_row_q <= s3_q.last_row;
    end
  end

  assign done_o     = done_q;
  assign out_row_o  = out_row_q;
  assign out_real_o = out_re_q;
  assign out_imag_o = out_im_q;
  assign last_row_o = last_row_q;

  // The sum only moves when an in-range entry reaches the accumulate stage.
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s2_q.valid |=> $stable(acc_re_q) && $stable(acc_im_q))
    else $error("accumulator changed without an entry");

  // A result strobe comes only in the cycle after a completed last-column sum.
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s3_q.valid && s3_q.last))
    else $error("result strobe without a completed row");

endmodule

[rtl/core/complex_matrix_vector_product_top.sv]
// Top level of the complex matrix-vector product: item decode, size register,
// vector store RAM and the multiply-accumulate datapath.
// Depends on cmvp_pkg, cmvp_ram and cmvp_mac.
//
//  channel  | ports                                            | handshake
//  ---------+--------------------------------------------------+--------------------------
//  item in  | command_i row_i index_i value_real_i value_imag_i | start high, busy low
//  result   | out_row_o out_real_o out_imag_o last_row_o        | done_o, one cycle, no stall
//  config   | psel penable pwrite paddr pwdata prdata pready    | APB, pready always high
//
// An item is taken in every cycle; busy stays low. A vector write lands in the
// store at its accept edge. A matrix entry reads the store at its accept edge,
// then passes the product registers and the accumulate registers; the row
// result is registered onto done_o from the completed last-column sum.
// Reset clears the size register to the largest dimension and the running sum;
// the vector store is not cleared and needs no clearing pass.
module complex_matrix_vector_product_top #(
  parameter int unsigned MAX_DIM    = cmvp_pkg::MAX_DIM_DEF,
  parameter int unsigned DATA_WIDTH = cmvp_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IDX_W  = $clog2(MAX_DIM),
  localparam int unsigned SIZE_W = $clog2(MAX_DIM + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Item channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [IDX_W-1:0]             row_i,
  input  logic [IDX_W-1:0]             index_i,
  input  logic signed [DATA_WIDTH-1:0] value_real_i,
  input  logic signed [DATA_WIDTH-1:0] value_imag_i,
  // Result channel
  output logic                         done_o,
  output logic [IDX_W-1:0]             out_row_o,
  output logic signed [DATA_WIDTH-1:0] out_real_o,
  output logic signed [DATA_WIDTH-1:0] out_imag_o,
  output logic                         last_row_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned WORD_W = 2 * DATA_WIDTH;

  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] eff_size, eff_last;
  logic [SIZE_W-1:0] row_ext, idx_ext;
  logic              accept, cfg_wr, vec_we, mat_rd;
  cmvp_pkg::ctrl_t   ctrl_d, s1_q;
  logic [IDX_W-1:0]  s1_row_q;
  logic signed [DATA_WIDTH-1:0] s1_re_q, s1_im_q;
  logic [WORD_W-1:0] rdata;

  assign accept = start && !busy;
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Size register write and read back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(MAX_DIM);
    end else if (cfg_wr && (paddr[2] == cmvp_pkg::REG_SIZE_IN_USE)) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == cmvp_pkg::REG_SIZE_IN_USE) ? 32'(size_q) : '0;

  // Size in use, with zero acting as one and large values clipped.
  always_comb begin
    if (size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (size_q > SIZE_W'(MAX_DIM)) begin
      eff_size = SIZE_W'(MAX_DIM);
    end else begin
      eff_size = size_q;
    end
    eff_last = eff_size - SIZE_W'(1);
  end

  // Item decode: vector writes go to the store, in-range entries to the datapath.
  assign row_ext = SIZE_W'(row_i);
  assign idx_ext = SIZE_W'(index_i);
  assign vec_we  = accept && (command_i == cmvp_pkg::CMD_VEC_WRITE)
                   && (idx_ext < SIZE_W'(MAX_DIM));
  assign mat_rd  = accept && (command_i == cmvp_pkg::CMD_MATRIX)
                   && (row_ext < eff_size) && (idx_ext < eff_size);

  always_comb begin
    ctrl_d.valid    = mat_rd;
    ctrl_d.first    = (index_i == '0);
    ctrl_d.last     = (idx_ext == eff_last);
    ctrl_d.last_row = (row_ext == eff_last);
  end

  // Entry stage, aligned with the store's read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_row_q <= row_i;
    s1_re_q  <= value_real_i;
    s1_im_q  <= value_imag_i;
  end

  // Vector store: real part in the upper half of the word.
  cmvp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_DIM)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (index_i),
    .wdata_i ({value_real_i, value_imag_i}),
    .re_i    (mat_rd),
    .raddr_i (index_i),
    .rdata_o (rdata)
  );

  cmvp_mac #(
    .DATA_WIDTH (DATA_WIDTH),
    .ROW_W      (IDX_W)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (s1_q),
    .row_i      (s1_row_q),
    .a_re_i     (s1_re_q),
    .a_im_i     (s1_im_q),
    .v_re_i     (rdata[WORD_W-1:DATA_WIDTH]),
    .v_im_i     (rdata[DATA_WIDTH-1:0]),
    .done_o     (done_o),
    .out_row_o  (out_row_o),
    .out_real_o (out_real_o),
    .out_imag_o (out_imag_o),
    .last_row_o (last_row_o)
  );

  // An entry enters the datapath only from an accepted matrix item.
  a_entry_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid |-> $past(start && (command_i == cmvp_pkg::CMD_MATRIX)))
    else $error("datapath entry without an accepted matrix item");

endmodule

[bench/complex_matrix_vector_product_top_tb.sv]
// Self-checking testbench for the complex matrix-vector product top level.
// Loads the vector store, streams matrix entries under several sizes and checks every row sum.
// Depends on cmvp_pkg and complex_matrix_vector_product_top.
module complex_matrix_vector_product_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM          = cmvp_pkg::MAX_DIM_DEF;
  localparam int unsigned DW           = cmvp_pkg::DATA_WIDTH_DEF;
  localparam int unsigned IDX_W        = $clog2(DIM);
  localparam int unsigned FRAC         = DW - 2;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [2:0]  SIZE_ADDR    = 3'(4 * cmvp_pkg::REG_SIZE_IN_USE);

  typedef logic signed [DW-1:0] sample_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam sample_t S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam sample_t S_ONE = sample_t'(1 << FRAC);

  // Kinds of random sample values.
  localparam int unsigned VAL_FULL    = 0;
  localparam int unsigned VAL_SMALL   = 1;
  localparam int unsigned VAL_EXTREME = 2;

  // One expected row sum.
  typedef struct {
    idx_t    row;
    sample_t re;
    sample_t im;
    logic    last;
  } row_sum_t;

  // Clock, reset and block ports.
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic        command_i    = cmvp_pkg::CMD_VEC_WRITE;
  idx_t        row_i        = '0;
  idx_t        index_i      = '0;
  sample_t     value_real_i = '0;
  sample_t     value_imag_i = '0;
  logic        done_o;
  idx_t        out_row_o;
  sample_t     out_real_o;
  sample_t     out_imag_o;
  logic        last_row_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the block.
  sample_t     vec_re [DIM];
  sample_t     vec_im [DIM];
  longint      sum_re      = 0;
  longint      sum_im      = 0;
  int unsigned dim_in_use  = DIM;
  row_sum_t    expected_rows [$];

  // Run bookkeeping.
  int unsigned error_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned live_items   = 0;
  int unsigned rows_checked = 0;
  int unsigned cycle_count  = 0;
  int unsigned next_row     = 0;
  bit          gaps_on      = 1'b1;

  complex_matrix_vector_product_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .row_i        (row_i),
    .index_i      (index_i),
    .value_real_i (value_real_i),
    .value_imag_i (value_imag_i),
    .done_o       (done_o),
    .out_row_o    (out_row_o),
    .out_real_o   (out_real_o),
    .out_imag_o   (out_imag_o),
    .last_row_o   (last_row_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d row sums still pending",
               cycle_count, expected_rows.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Shift the sum down to Q2.16 and clamp it to the sample range.
  function automatic sample_t scale_sum(input longint acc);
    longint v;
    v = acc >>> FRAC;
    if (v > longint'(S_MAX)) v = longint'(S_MAX);
    else if (v < longint'(S_MIN)) v = longint'(S_MIN);
    return v[DW-1:0];
  endfunction

  // Apply one accepted item to the predicted state; queue a row sum if it closes a row.
  function automatic void predict_row_sum(input logic cmd, input idx_t row, input idx_t col,
                                          input sample_t re, input sample_t im);
    longint   pr;
    longint   pi;
    row_sum_t res;
    if (cmd == cmvp_pkg::CMD_VEC_WRITE) begin
      vec_re[col] = re;
      vec_im[col] = im;
      live_items++;
      return;
    end
    // Entries outside the square in use leave everything untouched.
    if (row >= dim_in_use || col >= dim_in_use) return;
    live_items++;
    pr = longint'(re) * longint'(vec_re[col]) - longint'(im) * longint'(vec_im[col]);
    pi = longint'(re) * longint'(vec_im[col]) + longint'(im) * longint'(vec_re[col]);
    if (col == 0) begin
      sum_re = pr;
      sum_im = pi;
    end else begin
      sum_re += pr;
      sum_im += pi;
    end
    if (col == dim_in_use - 1) begin
      res.row  = row;
      res.re   = scale_sum(sum_re);
      res.im   = scale_sum(sum_im);
      res.last = (row == dim_in_use - 1);
      expected_rows.push_back(res);
    end
  endfunction

  function automatic sample_t rand_sample(input int unsigned mode);
    case (mode)
      VAL_FULL:  return sample_t'($urandom);
      VAL_SMALL: return sample_t'(int'($urandom_range(0, 8191)) - 4096);
      default: begin
        case ($urandom_range(0, 2))
          0:       return S_MAX;
          1:       return S_MIN;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Send one item, with a random gap before it while gaps are enabled.
  task automatic send_item(input logic cmd, input idx_t row, input idx_t col,
                           input sample_t re, input sample_t im);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    command_i    <= cmd;
    row_i        <= row;
    index_i      <= col;
    value_real_i <= re;
    value_imag_i <= im;
    do @(posedge clk_i); while (busy);
    items_sent++;
    predict_row_sum(cmd, row, col, re, im);
  endtask

  // Stream entries of one row; with may_skip set some columns are dropped.
  task automatic send_row(input int unsigned row, input int unsigned first_col,
                          input int unsigned last_col, input int unsigned mode,
                          input bit may_skip);
    for (int unsigned c = first_col; c <= last_col; c++) begin
      if (!may_skip || $urandom_range(0, 3) != 0)
        send_item(cmvp_pkg::CMD_MATRIX, idx_t'(row), idx_t'(c),
                  rand_sample(mode), rand_sample(mode));
    end
  endtask

  // Stop sending and let every outstanding row sum come out.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the size register, then read it back.
  task automatic write_size(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SIZE_ADDR;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // Zero acts as one and anything past the store depth as the full depth.
    dim_in_use = value[6:0];
    if (dim_in_use == 0) dim_in_use = 1;
    else if (dim_in_use > DIM) dim_in_use = DIM;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[6:0] !== value[6:0])
      report_mismatch($sformatf("size readback %0d, wrote %0d", prdata[6:0], value[6:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Size register: both extremes, out-of-range codes and a middle value.
  task automatic test_size_register();
    write_size(1);
    write_size(DIM);
    write_size(0);
    write_size(127);
    write_size(37);
  endtask

  // Every store position is written before any matrix entry reads it.
  task automatic test_vector_load();
    send_item(cmvp_pkg::CMD_VEC_WRITE, '0, 0, S_MAX, S_MAX);
    send_item(cmvp_pkg::CMD_VEC_WRITE, '0, 1, S_MIN, S_MIN);
    send_item(cmvp_pkg::CMD_VEC_WRITE, '0, 2, S_ONE, '0);
    send_item(cmvp_pkg::CMD_VEC_WRITE, '0, 3, '0, S_ONE);
    for (int unsigned i = 4; i < DIM; i++)
      send_item(cmvp_pkg::CMD_VEC_WRITE, idx_t'($urandom), idx_t'(i),
                rand_sample(VAL_FULL), rand_sample(VAL_FULL));
  endtask

  // Saturation, ignored entries, out-of-order columns and the size-one cases.
  task automatic test_edge_cases();
    wait_idle();
    write_size(4);
    // Full-scale rows saturate in both directions.
    for (int unsigned c = 0; c < 4; c++)
      send_item(cmvp_pkg::CMD_MATRIX, 0, idx_t'(c), S_MAX, S_MAX);
    for (int unsigned c = 0; c < 4; c++)
      send_item(cmvp_pkg::CMD_MATRIX, 1, idx_t'(c), S_MIN, S_MAX);
    // Row and column outside the size are dropped.
    send_item(cmvp_pkg::CMD_MATRIX, 4, 0, S_MAX, S_MIN);
    send_item(cmvp_pkg::CMD_MATRIX, 2, 5, S_MAX, S_MIN);
    send_row(2, 0, 3, VAL_SMALL, 0);
    // Skipped column, then a stray last-column entry that adds to the old sum.
    send_item(cmvp_pkg::CMD_MATRIX, 3, 0, S_ONE, '0);
    send_item(cmvp_pkg::CMD_MATRIX, 3, 2, '0, S_ONE);
    send_item(cmvp_pkg::CMD_MATRIX, 3, 3, S_MIN, S_MIN);
    send_item(cmvp_pkg::CMD_MATRIX, 1, 3, S_ONE, S_ONE);
    // Size one: column 0 is also the last column.
    wait_idle();
    write_size(1);
    send_item(cmvp_pkg::CMD_MATRIX, 0, 0, S_MAX, S_MIN);
    send_item(cmvp_pkg::CMD_MATRIX, 1, 0, S_MAX, S_MIN);
    wait_idle();
    write_size(0);
    send_item(cmvp_pkg::CMD_MATRIX, 0, 0, S_MIN, S_ONE);
    // Oversized code acts as the full depth; the lone entry reports the last row.
    wait_idle();
    write_size(127);
    send_item(cmvp_pkg::CMD_MATRIX, 63, 63, S_MAX, '0);
  endtask

  // Mostly whole rows with random content, plus store rewrites, broken rows and noise.
  task automatic run_phase(input int unsigned size, input int unsigned budget);
    int unsigned goal;
    int unsigned pick;
    int unsigned mode;
    int unsigned r;
    int unsigned c0;
    int unsigned c1;
    wait_idle();
    write_size(size);
    next_row = 0;
    goal = live_items + budget;
    while (live_items < goal) begin
      pick = $urandom_range(0, 99);
      mode = $urandom_range(0, 2);
      if (pick < 70) begin
        send_row(next_row, 0, dim_in_use - 1, mode, 0);
        next_row = (next_row + 1) % dim_in_use;
      end else if (pick < 80) begin
        send_item(cmvp_pkg::CMD_VEC_WRITE, idx_t'($urandom), idx_t'($urandom),
                  rand_sample(mode), rand_sample(mode));
      end else if (pick < 90) begin
        r  = $urandom_range(0, dim_in_use - 1);
        c0 = $urandom_range(0, dim_in_use - 1);
        c1 = $urandom_range(c0, dim_in_use - 1);
        send_row(r, c0, c1, mode, 1);
      end else begin
        send_item(logic'($urandom_range(0, 1)), idx_t'($urandom), idx_t'($urandom),
                  rand_sample(VAL_FULL), rand_sample(VAL_FULL));
      end
    end
  endtask

  task automatic test_random_products();
    int unsigned phase_sizes [10] = '{64, 1, 2, 5, 64, 13, 32, 3, 1, 64};
    foreach (phase_sizes[i]) run_phase(phase_sizes[i], 180);
  endtask

  // Compare each row sum with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    row_sum_t want;
    if (rst_ni && done_o) begin
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected result for row %0d", out_row_o));
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (out_row_o !== want.row)
          report_mismatch($sformatf("row %0d, expected %0d", out_row_o, want.row));
        if (out_real_o !== want.re)
          report_mismatch($sformatf("row %0d real %0d, expected %0d",
                                    want.row, out_real_o, want.re));
        if (out_imag_o !== want.im)
          report_mismatch($sformatf("row %0d imag %0d, expected %0d",
                                    want.row, out_imag_o, want.im));
        if (last_row_o !== want.last)
          report_mismatch($sformatf("row %0d last_row %b, expected %b",
                                    want.row, last_row_o, want.last));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_size_register();
    test_vector_load();
    test_edge_cases();
    test_random_products();
    wait_idle();

    $display("covered %0d items (%0d in range) and %0d row sums", items_sent, live_items,
             rows_checked);
    $display("sizes 0, 1, 2, 3, 4, 5, 13, 32, 37, 64 and 127 were programmed");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
